FILE: src/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants of the keyed member cache.
// ----------------------------------------------------------------------------
package kmc_pkg;

    localparam int FIELD_BITS = 32;

    // Item kinds
    localparam logic KIND_REMEMBER = 1'b0;
    localparam logic KIND_QUERY    = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [FIELD_BITS-1:0] key_id;
        logic [FIELD_BITS-1:0] member_id;
        logic                  exempt;
        logic [FIELD_BITS-1:0] frame_now;
    } in_word_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] member_out;
        logic                  last;
    } out_word_t;

endpackage

FILE: src/kmc_front.sv
// ----------------------------------------------------------------------------
// kmc_front
// Accepts input words, drops ignored ones and pushes the rest into a
// two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module kmc_front #(
    parameter int ID_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  kmc_pkg::in_word_t in_word,
    output logic              q_valid,
    output kmc_pkg::in_word_t q_word,
    input  logic              q_pop
);

    kmc_pkg::in_word_t        slot_reg [2];
    logic                     rd_ptr_reg;
    logic                     wr_ptr_reg;
    logic [1:0]               fill_reg;
    logic [ID_BITS-1:0]       key_m;
    logic [ID_BITS-1:0]       mem_m;
    logic                     keep;
    logic                     push;
    kmc_pkg::in_word_t        masked;

    assign busy = (fill_reg == 2'd2);

    // Classify: key and member are taken modulo 2^ID_BITS
    always_comb
    begin
        key_m  = ID_BITS'(in_word.key_id);
        mem_m  = ID_BITS'(in_word.member_id);
        masked = in_word;
        masked.key_id    = kmc_pkg::FIELD_BITS'(key_m);
        masked.member_id = kmc_pkg::FIELD_BITS'(mem_m);
        if (in_word.kind == kmc_pkg::KIND_REMEMBER)
            keep = (key_m != '0) && (mem_m != '0) && !in_word.exempt;
        else
            keep = (key_m != '0);
    end

    assign push    = start && !busy && keep;
    assign q_valid = (fill_reg != 2'd0);
    assign q_word  = slot_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= masked;
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

FILE: src/kmc_back.sv
// ----------------------------------------------------------------------------
// kmc_back
// Sequencer that scans the entry table and member lists for one word.
// ----------------------------------------------------------------------------
module kmc_back #(
    parameter int ENTRIES = 256,
    parameter int SLOTS   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  kmc_pkg::in_word_t  q_word,
    output logic               q_pop,
    output logic               strobe,
    output kmc_pkg::out_word_t result
);

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int FB = kmc_pkg::FIELD_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EREAD = 3'd3;
    localparam logic [2:0] S_LIST  = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    // Entry table (key, frame, count) and member store
    logic [FB-1:0] key_mem  [ENTRIES];
    logic [FB-1:0] time_mem [ENTRIES];
    logic [CW-1:0] cnt_mem  [ENTRIES];
    logic [FB-1:0] mem_store [ENTRIES*SLOTS];

    logic [2:0]    state_reg;
    logic [EW:0]   idx_reg;
    logic [EW-1:0] oldest_reg;
    logic [FB-1:0] oldest_time_reg;
    logic [EW-1:0] chosen_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] k_reg;
    logic [FB-1:0] rd_key_reg;
    logic [FB-1:0] rd_time_reg;
    logic [CW-1:0] rd_cnt_reg;
    logic [FB-1:0] rd_mem_reg;
    logic          rd_ok_reg;
    logic          pend_reg;
    logic          dup_reg;
    logic          strobe_reg;
    kmc_pkg::out_word_t result_reg;

    logic [EW-1:0] idx_lo;
    logic [EW+SW-1:0] list_addr;
    logic [EW+SW-1:0] wr_addr;
    logic          is_query;

    function automatic logic [EW-1:0] oldest_prev(input logic [EW:0] i);
        logic [EW:0] p;
        p = i - 1'b1;
        return p[EW-1:0];
    endfunction

    assign idx_lo    = idx_reg[EW-1:0];
    assign is_query  = (q_word.kind == kmc_pkg::KIND_QUERY);
    assign list_addr = (EW+SW)'(chosen_reg) * (EW+SW)'(SLOTS) + (EW+SW)'(k_reg);
    assign wr_addr   = (EW+SW)'(chosen_reg) * (EW+SW)'(SLOTS) + (EW+SW)'(n_reg);
    assign strobe    = strobe_reg;
    assign result    = result_reg;

    // Pop the word on every path back to idle: query miss, duplicate,
    // end of list check, end of emit
    assign q_pop     = (state_reg == S_SCAN && rd_ok_reg && is_query
                        && idx_reg == (EW+1)'(ENTRIES) && rd_key_reg != q_word.key_id)
                    || (state_reg == S_CHECK && pend_reg && rd_mem_reg == q_word.member_id)
                    || (state_reg == S_CHECK && !pend_reg && k_reg == n_reg)
                    || (state_reg == S_EMIT && k_reg == n_reg);

    // Registered reads
    always_ff @(posedge clk)
    begin
        rd_key_reg  <= key_mem[idx_lo];
        rd_time_reg <= time_mem[idx_lo];
        rd_cnt_reg  <= cnt_mem[chosen_reg];
        rd_mem_reg  <= mem_store[list_addr[EW+SW-1:0]];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            idx_reg    <= '0;
            rd_ok_reg  <= 1'b0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            k_reg      <= '0;
            n_reg      <= '0;
            chosen_reg <= '0;
            dup_reg    <= 1'b0;
            oldest_reg <= '0;
            oldest_time_reg <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    key_mem[idx_lo]  <= '0;
                    time_mem[idx_lo] <= '0;
                    cnt_mem[idx_lo]  <= '0;
                    if (idx_reg == (EW+1)'(ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                        idx_reg   <= '0;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg  <= S_SCAN;
                        idx_reg    <= '0;
                        rd_ok_reg  <= 1'b0;
                        oldest_reg <= '0;
                    end
                end
                S_SCAN:
                begin
                    // one entry per cycle: idx issues read, rd_* holds previous
                    if (rd_ok_reg)
                    begin
                        if (rd_key_reg == q_word.key_id || (!is_query && rd_key_reg == '0))
                        begin
                            chosen_reg <= oldest_prev(idx_reg);
                            if (!is_query && rd_key_reg == '0)
                            begin
                                key_mem[oldest_prev(idx_reg)] <= q_word.key_id;
                                cnt_mem[oldest_prev(idx_reg)] <= '0;
                            end
                            state_reg <= S_EREAD;
                        end
                        else
                        begin
                            if (idx_reg == (EW+1)'(1) || rd_time_reg < oldest_time_reg)
                            begin
                                oldest_reg      <= oldest_prev(idx_reg);
                                oldest_time_reg <= rd_time_reg;
                            end
                            if (idx_reg == (EW+1)'(ENTRIES))
                            begin
                                if (is_query)
                                    state_reg <= S_IDLE;
                                else
                                begin
                                    if (rd_time_reg < oldest_time_reg)
                                        chosen_reg <= oldest_prev(idx_reg);
                                    else
                                        chosen_reg <= oldest_reg;
                                    state_reg <= S_EREAD;
                                    if (rd_time_reg < oldest_time_reg)
                                    begin
                                        key_mem[oldest_prev(idx_reg)] <= q_word.key_id;
                                        cnt_mem[oldest_prev(idx_reg)] <= '0;
                                    end
                                    else
                                    begin
                                        key_mem[oldest_reg] <= q_word.key_id;
                                        cnt_mem[oldest_reg] <= '0;
                                    end
                                end
                            end
                        end
                    end
                    if (idx_reg != (EW+1)'(ENTRIES))
                        idx_reg <= idx_reg + 1'b1;
                    rd_ok_reg <= 1'b1;
                end
                S_EREAD:
                begin
                    // wait for count read of chosen entry
                    if (!rd_ok_reg)
                    begin
                        n_reg <= (rd_cnt_reg > CW'(SLOTS)) ? CW'(SLOTS) : rd_cnt_reg;
                        k_reg <= '0;
                        dup_reg <= 1'b0;
                        pend_reg <= 1'b0;
                        if (!is_query)
                            time_mem[chosen_reg] <= q_word.frame_now;
                        state_reg <= is_query ? S_EMIT : S_CHECK;
                    end
                    rd_ok_reg <= 1'b0;
                end
                S_CHECK:
                begin
                    // pend marks a read in flight for slot k-1
                    if (pend_reg && rd_mem_reg == q_word.member_id)
                        dup_reg <= 1'b1;
                    if (k_reg != n_reg && !(pend_reg && rd_mem_reg == q_word.member_id))
                    begin
                        k_reg    <= k_reg + 1'b1;
                        pend_reg <= 1'b1;
                    end
                    else
                        pend_reg <= 1'b0;
                    if ((pend_reg && rd_mem_reg == q_word.member_id) || dup_reg)
                        state_reg <= S_IDLE;
                    else if (!pend_reg && k_reg == n_reg)
                    begin
                        if (n_reg < CW'(SLOTS))
                        begin
                            mem_store[wr_addr[EW+SW-1:0]] <= q_word.member_id;
                            cnt_mem[chosen_reg] <= n_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (pend_reg)
                    begin
                        strobe_reg <= 1'b1;
                        result_reg.member_out <= rd_mem_reg;
                        result_reg.last <= (k_reg == n_reg);
                    end
                    if (k_reg != n_reg)
                    begin
                        k_reg    <= k_reg + 1'b1;
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/keyed_member_cache_lru.sv
// ----------------------------------------------------------------------------
// keyed_member_cache_lru
// Fully associative keyed member cache with oldest-frame replacement.
// ----------------------------------------------------------------------------
// channel  | handshake            | word
// input    | start / busy         | in_word  (kmc_pkg::in_word_t)
// output   | strobe (no stall)    | result   (kmc_pkg::out_word_t)
//
// An item finds its entry by idle pickup, a table scan of one table read per
// cycle and a count read, then walks its member list.
// After reset a clearing pass over all ENTRIES entries runs before the first item.
// A two-word queue lets start be taken while the back end works.
// A query emits one word per cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module keyed_member_cache_lru #(
    parameter int ENTRIES = 256,
    parameter int SLOTS   = 64,
    parameter int ID_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  kmc_pkg::in_word_t  in_word,
    output logic               strobe,
    output kmc_pkg::out_word_t result
);

    logic              q_valid;
    logic              q_pop;
    kmc_pkg::in_word_t q_word;

    kmc_front #(.ID_BITS(ID_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .in_word(in_word), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
    );

    kmc_back #(.ENTRIES(ENTRIES), .SLOTS(SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_word(q_word),
        .q_pop(q_pop), .strobe(strobe), .result(result)
    );

endmodule

FILE: src/kmc_checker.sv
// ----------------------------------------------------------------------------
// kmc_port_checks
// Port-level checks of the keyed member cache.
// ----------------------------------------------------------------------------
module kmc_port_checks (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               strobe,
    input kmc_pkg::out_word_t result
);

    // emitted members are never zero
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> result.member_out != '0)
        else $error("zero member emitted");

    // busy is released only one word at a time, so it cannot rise without start
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    // busy right after reset is low
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !busy || !rst_n)
        else $error("busy after reset");

endmodule

bind keyed_member_cache_lru kmc_port_checks u_kmc_port_checks (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .strobe(strobe), .result(result)
);

FILE: tb/kmc_checker.sv
// ----------------------------------------------------------------------------
// kmc_checker
// Watches the command and result channels of the keyed member cache, keeps
// its own copy of the table, predicts the member words of every query and
// compares each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module kmc_checker
    import kmc_pkg::*;
#(
    parameter int ENTRIES = 256,
    parameter int SLOTS   = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  in_word_t  in_word,
    input  logic      strobe,
    input  out_word_t result,
    output int        fail_count,
    output int        pending,
    output int        words_seen
);

    // Shadow copy of the table
    logic [FIELD_BITS-1:0] tbl_key   [ENTRIES];
    logic [FIELD_BITS-1:0] tbl_frame [ENTRIES];
    int                    tbl_count [ENTRIES];
    logic [FIELD_BITS-1:0] tbl_member[ENTRIES][SLOTS];

    out_word_t members_due[$];

    // Store a member under a key: hit, first empty slot, or evict the oldest
    function automatic void store_member(in_word_t w);
        int  pick;
        int  oldest;
        bit  dup;
        pick   = -1;
        oldest = 0;
        dup    = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_key[i] == w.key_id) begin
                pick = i;
                break;
            end
            if (tbl_key[i] == '0) begin
                tbl_key[i]   = w.key_id;
                tbl_count[i] = 0;
                pick = i;
                break;
            end
            if (tbl_frame[i] < tbl_frame[oldest])
                oldest = i;
        end
        if (pick < 0) begin
            pick = oldest;
            tbl_key[pick]   = w.key_id;
            tbl_count[pick] = 0;
        end
        tbl_frame[pick] = w.frame_now;
        for (int k = 0; k < tbl_count[pick]; k++)
            if (tbl_member[pick][k] == w.member_id)
                dup = 1;
        if (!dup && tbl_count[pick] < SLOTS) begin
            tbl_member[pick][tbl_count[pick]] = w.member_id;
            tbl_count[pick]++;
        end
    endfunction

    // Queue the listed members of a queried key; a miss yields nothing
    function automatic void list_members(in_word_t w);
        out_word_t o;
        if (w.key_id == '0)
            return;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_key[i] == w.key_id) begin
                for (int k = 0; k < tbl_count[i]; k++) begin
                    o.member_out = tbl_member[i][k];
                    o.last       = (k + 1 == tbl_count[i]);
                    members_due.push_back(o);
                end
                return;
            end
        end
    endfunction

    // Compare results first, then predict the word accepted at this edge
    always @(posedge clk or negedge rst_n) begin
        out_word_t exp_w;
        if (!rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tbl_key[i]   = '0;
                tbl_frame[i] = '0;
                tbl_count[i] = 0;
            end
            members_due.delete();
            fail_count = 0;
            words_seen = 0;
        end else begin
            if (strobe) begin
                words_seen++;
                if (members_due.size() == 0) begin
                    $error("unexpected result word: member_out %h last %b",
                           result.member_out, result.last);
                    fail_count++;
                end else begin
                    exp_w = members_due.pop_front();
                    if (result.member_out !== exp_w.member_out) begin
                        $error("member_out: expected %h, got %h",
                               exp_w.member_out, result.member_out);
                        fail_count++;
                    end
                    if (result.last !== exp_w.last) begin
                        $error("last: expected %b, got %b", exp_w.last, result.last);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                if (in_word.kind == KIND_REMEMBER) begin
                    if (in_word.key_id != '0 && in_word.member_id != '0 && !in_word.exempt)
                        store_member(in_word);
                end else begin
                    list_members(in_word);
                end
            end
        end
        pending = members_due.size();
    end

endmodule

FILE: tb/keyed_member_cache_lru_tb.sv
// ----------------------------------------------------------------------------
// keyed_member_cache_lru_tb
// Drives remember and query commands into the keyed member cache with random
// gaps: a directed opening, a full member list and a random mix over a small
// key pool. A checker beside the block predicts and compares every result
// word.
// ----------------------------------------------------------------------------
module keyed_member_cache_lru_tb;
    import kmc_pkg::*;

    localparam int  ENTRIES   = 256;
    localparam int  SLOTS     = 64;
    localparam int  TAIL      = 800;
    localparam int  MIX_WORDS = 45;
    localparam longint LIMIT  = 3000000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  in_word;
    logic      strobe;
    out_word_t result;
    int        fail_count;
    int        pending;
    int        words_seen;
    longint    cycles;
    int        words_sent;

    logic [FIELD_BITS-1:0] key_pool[8];
    logic [FIELD_BITS-1:0] member_pool[8];

    keyed_member_cache_lru #(.ENTRIES(ENTRIES), .SLOTS(SLOTS), .ID_BITS(FIELD_BITS)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .in_word(in_word),
        .strobe (strobe),
        .result (result)
    );

    kmc_checker #(.ENTRIES(ENTRIES), .SLOTS(SLOTS)) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_word   (in_word),
        .strobe    (strobe),
        .result    (result),
        .fail_count(fail_count),
        .pending   (pending),
        .words_seen(words_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    function automatic in_word_t make_word(logic kind, logic [FIELD_BITS-1:0] key,
                                           logic [FIELD_BITS-1:0] member, logic exempt,
                                           logic [FIELD_BITS-1:0] frame);
        in_word_t w;
        w.kind      = kind;
        w.key_id    = key;
        w.member_id = member;
        w.exempt    = exempt;
        w.frame_now = frame;
        return w;
    endfunction

    // Present one command word and hold it until the block takes it
    task automatic send(in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (busy);
        words_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    initial
    begin
        logic [FIELD_BITS-1:0] k;
        logic [127:0]          noise;
        int r;
        cycles     = 0;
        words_sent = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        in_word    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: misses, ignored items, extremes, duplicates
        send(make_word(KIND_QUERY, 32'h0000_0001, '0, 1'b0, '0));
        send(make_word(KIND_QUERY, '0, '1, 1'b1, '1));
        send(make_word(KIND_REMEMBER, '0, 32'h11, 1'b0, 32'd5));
        send(make_word(KIND_REMEMBER, 32'h55, '0, 1'b0, 32'd5));
        send(make_word(KIND_REMEMBER, 32'h55, 32'h11, 1'b1, 32'd5));
        send(make_word(KIND_QUERY, 32'h55, '0, 1'b0, '0));
        send(make_word(KIND_REMEMBER, '1, '1, 1'b0, '1));
        send(make_word(KIND_REMEMBER, '1, 32'h0000_0001, 1'b0, '0));
        send(make_word(KIND_REMEMBER, '1, '1, 1'b0, 32'h8000_0000));
        send(make_word(KIND_QUERY, '1, '0, 1'b0, '0));
        send(make_word(KIND_REMEMBER, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 1'b0, 32'd7));
        send(make_word(KIND_REMEMBER, 32'hA5A5_5A5A, 32'h8000_0000, 1'b0, 32'd8));
        send(make_word(KIND_QUERY, 32'hA5A5_5A5A, '1, 1'b1, '1));
        send(make_word(KIND_QUERY, 32'h8000_0000, '0, 1'b0, '0));
        drain();

        // One key driven past a full member list
        k = $urandom() | 32'h1;
        for (int i = 0; i < SLOTS + 2; i++)
            send(make_word(KIND_REMEMBER, k, $urandom() | 32'h1, 1'b0, i));
        send(make_word(KIND_QUERY, k, $urandom(), 1'b0, $urandom()));
        drain();

        // Random mix over a small key and member pool, a little noise
        for (int i = 0; i < 8; i++)
        begin
            key_pool[i]    = $urandom() | 32'h1;
            member_pool[i] = $urandom() | 32'h1;
        end
        for (int i = 0; i < MIX_WORDS; i++)
        begin
            in_word_t w;
            r = $urandom_range(99);
            w = make_word($urandom_range(99) < 30 ? KIND_QUERY : KIND_REMEMBER,
                          key_pool[$urandom_range(7)],
                          $urandom_range(1) ? member_pool[$urandom_range(7)] : $urandom(),
                          1'b0, $urandom());
            noise = {$urandom(), $urandom(), $urandom(), $urandom()};
            if (r < 5)
                w = noise[$bits(in_word_t)-1:0];
            else if (r < 10)
                w.exempt = 1'b1;
            else if (r < 14)
                w.key_id = $urandom();
            send(w);
            if (i == MIX_WORDS / 2)
                drain();
        end
        for (int i = 0; i < 8; i++)
            send(make_word(KIND_QUERY, key_pool[i], '0, 1'b0, '0));

        drain();
        $display("sent %0d command words, checked %0d result words", words_sent, words_seen);
        $display("covered ignored items, full member list, random mix with idle drains");
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
